// ===== rtl/ppc_pkg.sv =====
// ----------------------------------------------------------------------------
// ppc_pkg
// Shared types, constants and Q16.16 helpers of the plane collider.
// ----------------------------------------------------------------------------
`default_nettype none

package ppc_pkg;

    // register indexes
    localparam logic [2:0] REG_NORMAL_X       = 3'd0;
    localparam logic [2:0] REG_NORMAL_Y       = 3'd1;
    localparam logic [2:0] REG_NORMAL_Z       = 3'd2;
    localparam logic [2:0] REG_PLANE_OFFSET   = 3'd3;
    localparam logic [2:0] REG_VELOCITY_SCALE = 3'd4;
    localparam logic [2:0] REG_BOUNCINESS     = 3'd5;
    localparam logic [2:0] REG_COLLISION_KIND = 3'd6;

    // collision responses; the fourth code acts as none
    localparam logic [1:0] KIND_NONE   = 2'd0;
    localparam logic [1:0] KIND_BOUNCE = 2'd1;
    localparam logic [1:0] KIND_FLOW   = 2'd2;

    localparam logic signed [31:0] BOUNCINESS_RESET = 32'sd65536;

    // square root: 32 result bits, four per stage
    localparam int SQRT_STAGES = 8;
    localparam int SQRT_STEPS  = 4;
    // front latency up to the sqrt input and up to its mid result
    localparam int FRONT_SQRT_LAT = 2;
    localparam int FRONT_MID_LAT  = 5;
    localparam int MID_DELAY      = FRONT_SQRT_LAT + SQRT_STAGES - FRONT_MID_LAT;

    typedef struct packed {
        logic signed [31:0] nx;
        logic signed [31:0] ny;
        logic signed [31:0] nz;
        logic signed [31:0] off;
        logic signed [31:0] vs;
        logic signed [31:0] bnc;
        logic [1:0]         kind;
    } t_cfg;

    typedef struct packed {
        logic signed [2:0][31:0] pos;
        logic signed [2:0][31:0] dir;
        logic [30:0]             st;
    } t_item;

    // front result: position after any step back, both directions, time step, hit
    typedef struct packed {
        logic [2:0][31:0] pos;
        logic [2:0][31:0] dir;
        logic [2:0][31:0] bdir;
        logic [30:0]      st;
        logic             hit;
    } t_mid;

    typedef struct packed {
        logic [2:0][31:0] pos;
        logic [2:0][31:0] dir;
        logic             collided;
    } t_res;

    // round half up of a Q32.32 product to Q32.16
    function automatic logic signed [47:0] rq(input logic signed [63:0] p);
        logic signed [63:0] tmp;
        tmp = p + 64'sd32768;
        return signed'(tmp[63:16]);
    endfunction

    function automatic logic signed [47:0] mulq(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        logic signed [63:0] p;
        p = 64'(a) * 64'(b);
        return rq(p);
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
        if (v > 50'sd2147483647) begin
            return 32'sh7FFFFFFF;
        end else if (v < -50'sd2147483648) begin
            return 32'sh80000000;
        end
        return signed'(v[31:0]);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/ppc_if.sv =====
// ----------------------------------------------------------------------------
// ppc_in_if / ppc_out_if
// Valid/ready channels carrying particle items and collider results.
// ----------------------------------------------------------------------------
`default_nettype none

interface ppc_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;
    logic [30:0]        step_time;

    modport source (output valid, pos_x, pos_y, pos_z, dir_x, dir_y, dir_z, step_time,
                    input ready);
    modport sink (input valid, pos_x, pos_y, pos_z, dir_x, dir_y, dir_z, step_time,
                  output ready);
endinterface

interface ppc_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] new_pos_x;
    logic signed [31:0] new_pos_y;
    logic signed [31:0] new_pos_z;
    logic signed [31:0] new_dir_x;
    logic signed [31:0] new_dir_y;
    logic signed [31:0] new_dir_z;
    logic               collided;

    modport source (output valid, new_pos_x, new_pos_y, new_pos_z,
                    new_dir_x, new_dir_y, new_dir_z, collided, input ready);
    modport sink (input valid, new_pos_x, new_pos_y, new_pos_z,
                  new_dir_x, new_dir_y, new_dir_z, collided, output ready);
endinterface

`default_nettype wire

// ===== rtl/ppc_front.sv =====
// ----------------------------------------------------------------------------
// ppc_front
// Plane tests, step back and bounce direction; also the squared speed.
// ----------------------------------------------------------------------------
`default_nettype none

module ppc_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire logic          i_valid,
    input  wire ppc_pkg::t_item i_item,
    input  wire ppc_pkg::t_cfg  i_cfg,
    output logic [63:0]        o_sq,
    output logic               o_valid,
    output ppc_pkg::t_mid      o_mid
);
    import ppc_pkg::*;

    logic signed [2:0][31:0] nrm;
    assign nrm[0] = i_cfg.nx;
    assign nrm[1] = i_cfg.ny;
    assign nrm[2] = i_cfg.nz;

    // stage 1: products
    logic                    r_v1;
    logic signed [2:0][31:0] r1_pos, r1_dir;
    logic [30:0]             r1_st;
    logic signed [2:0][47:0] r1_t, r1_nd, r1_np;
    logic [2:0][63:0]        r1_sq;
    // stage 2: sums
    logic                    r_v2;
    logic signed [2:0][31:0] r2_pos, r2_back, r2_pred, r2_dir;
    logic [30:0]             r2_st;
    logic signed [49:0]      r2_d0;
    logic signed [31:0]      r2_k;
    logic [63:0]             r2_sq;
    // stage 3: second plane test products
    logic                    r_v3;
    logic signed [2:0][31:0] r3_pos, r3_dir;
    logic [30:0]             r3_st;
    logic                    r3_hit0;
    logic signed [2:0][47:0] r3_npd, r3_kn;
    // stage 4: hit and reflection
    logic                    r_v4;
    logic signed [2:0][31:0] r4_pos, r4_dir, r4_r;
    logic [30:0]             r4_st;
    logic                    r4_hit;
    // stage 5
    logic                    r_v5;
    t_mid                    r5_mid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

    // element selects of packed arrays are unsigned, hence the signed casts
    always_ff @(posedge i_clk) begin
        logic [31:0]        a;
        logic signed [49:0] sum_np, sum_nd, sum_npd;
        if (i_en) begin
            // stage 1
            r1_pos <= i_item.pos;
            r1_dir <= i_item.dir;
            r1_st  <= i_item.st;
            for (int i = 0; i < 3; i++) begin
                a = i_item.dir[i][31] ? (~i_item.dir[i] + 32'd1) : i_item.dir[i];
                r1_t[i]  <= mulq(i_cfg.vs, i_item.dir[i]);
                r1_nd[i] <= mulq(nrm[i], i_item.dir[i]);
                r1_np[i] <= mulq(nrm[i], i_item.pos[i]);
                r1_sq[i] <= 64'(a) * 64'(a);
            end
            // stage 2
            sum_np = 50'(signed'(r1_np[0])) + 50'(signed'(r1_np[1]))
                   + 50'(signed'(r1_np[2]));
            sum_nd = 50'(signed'(r1_nd[0])) + 50'(signed'(r1_nd[1]))
                   + 50'(signed'(r1_nd[2]));
            r2_d0  <= sum_np + 50'(i_cfg.off);
            r2_k   <= sat32(sum_nd);
            r2_sq  <= r1_sq[0] + r1_sq[1] + r1_sq[2];
            r2_pos <= r1_pos;
            r2_dir <= r1_dir;
            r2_st  <= r1_st;
            for (int i = 0; i < 3; i++) begin
                r2_pred[i] <= sat32(50'(signed'(r1_pos[i])) + 50'(signed'(r1_t[i])));
                r2_back[i] <= sat32(50'(signed'(r1_pos[i])) - 50'(signed'(r1_t[i])));
            end
            // stage 3: on or behind the plane now means step back
            r3_hit0 <= (r2_d0 <= 50'sd0);
            r3_pos  <= (r2_d0 <= 50'sd0) ? r2_back : r2_pos;
            r3_dir  <= r2_dir;
            r3_st   <= r2_st;
            for (int i = 0; i < 3; i++) begin
                r3_npd[i] <= mulq(nrm[i], r2_pred[i]);
                r3_kn[i]  <= mulq(r2_k, nrm[i]);
            end
            // stage 4
            sum_npd = 50'(signed'(r3_npd[0])) + 50'(signed'(r3_npd[1]))
                    + 50'(signed'(r3_npd[2])) + 50'(i_cfg.off);
            r4_hit <= r3_hit0 || (sum_npd <= 50'sd0);
            r4_pos <= r3_pos;
            r4_dir <= r3_dir;
            r4_st  <= r3_st;
            for (int i = 0; i < 3; i++) begin
                r4_r[i] <= sat32(50'(signed'(r3_dir[i])) - (50'(signed'(r3_kn[i])) <<< 1));
            end
            // stage 5
            r5_mid.pos <= r4_pos;
            r5_mid.dir <= r4_dir;
            r5_mid.st  <= r4_st;
            r5_mid.hit <= r4_hit;
            for (int i = 0; i < 3; i++) begin
                r5_mid.bdir[i] <= sat32(50'(mulq(r4_r[i], i_cfg.bnc)));
            end
        end
    end

    assign o_sq    = r2_sq;
    assign o_valid = r_v5;
    assign o_mid   = r5_mid;

endmodule

`default_nettype wire

// ===== rtl/ppc_isqrt.sv =====
// ----------------------------------------------------------------------------
// ppc_isqrt
// Pipelined integer square root of a 64-bit radicand, four bits per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module ppc_isqrt (
    input  wire logic        i_clk,
    input  wire logic        i_en,
    input  wire logic [63:0] i_rad,
    output logic [31:0]      o_root
);
    import ppc_pkg::*;

    logic [63:0] r_x   [SQRT_STAGES];
    logic [63:0] r_res [SQRT_STAGES];

    for (genvar j = 0; j < SQRT_STAGES; j++) begin : g_stage
        logic [63:0] x_in, res_in, n_x, n_res;

        if (j == 0) begin : g_first
            assign x_in   = i_rad;
            assign res_in = 64'd0;
        end else begin : g_next
            assign x_in   = r_x[j-1];
            assign res_in = r_res[j-1];
        end

        always_comb begin
            logic [63:0] b;
            n_x   = x_in;
            n_res = res_in;
            for (int q = 0; q < SQRT_STEPS; q++) begin
                b = 64'd1 << (62 - 2 * (j * SQRT_STEPS + q));
                if (n_x >= n_res + b) begin
                    n_x   = n_x - (n_res + b);
                    n_res = (n_res >> 1) + b;
                end else begin
                    n_res = n_res >> 1;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[j]   <= n_x;
                r_res[j] <= n_res;
            end
        end
    end

    assign o_root = r_res[SQRT_STAGES-1][31:0];

endmodule

`default_nettype wire

// ===== rtl/ppc_back.sv =====
// ----------------------------------------------------------------------------
// ppc_back
// Aligns the front result with the speed, applies flow and picks the result.
// ----------------------------------------------------------------------------
`default_nettype none

module ppc_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire logic          i_valid,
    input  wire ppc_pkg::t_mid  i_mid,
    input  wire logic [31:0]   i_len,
    input  wire ppc_pkg::t_cfg  i_cfg,
    output logic               o_valid,
    output ppc_pkg::t_res      o_res
);
    import ppc_pkg::*;

    logic               r_dv [MID_DELAY];
    t_mid               r_dm [MID_DELAY];
    logic               r_v11, r_v12, r_v13;
    t_mid               r11_mid, r12_mid;
    logic [62:0]        r11_p;
    logic signed [2:0][47:0] r12_mn;
    t_res               r13_res;

    logic signed [2:0][31:0] nrm;
    assign nrm[0] = i_cfg.nx;
    assign nrm[1] = i_cfg.ny;
    assign nrm[2] = i_cfg.nz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MID_DELAY; i++) r_dv[i] <= 1'b0;
            r_v11 <= 1'b0;
            r_v12 <= 1'b0;
            r_v13 <= 1'b0;
        end else if (i_en) begin
            r_dv[0] <= i_valid;
            for (int i = 1; i < MID_DELAY; i++) r_dv[i] <= r_dv[i-1];
            r_v11 <= r_dv[MID_DELAY-1];
            r_v12 <= r_v11;
            r_v13 <= r_v12;
        end
    end

    always_ff @(posedge i_clk) begin
        logic [63:0] rnd;
        logic [30:0] m;
        logic        kind_bounce, kind_flow;
        if (i_en) begin
            r_dm[0] <= i_mid;
            for (int i = 1; i < MID_DELAY; i++) r_dm[i] <= r_dm[i-1];
            // stage 11: time step times speed
            r11_mid <= r_dm[MID_DELAY-1];
            r11_p   <= 63'(r_dm[MID_DELAY-1].st) * 63'(i_len);
            // stage 12: clamp the push distance, scale the normal
            rnd = 64'(r11_p) + 64'd32768;
            m   = (rnd[63:16] > 48'h7FFFFFFF) ? 31'h7FFFFFFF : rnd[46:16];
            r12_mid <= r11_mid;
            for (int i = 0; i < 3; i++) begin
                r12_mn[i] <= mulq(signed'({1'b0, m}), nrm[i]);
            end
            // stage 13: response select
            kind_bounce = r12_mid.hit && (i_cfg.kind == KIND_BOUNCE);
            kind_flow   = r12_mid.hit && (i_cfg.kind == KIND_FLOW);
            r13_res.collided <= r12_mid.hit;
            for (int i = 0; i < 3; i++) begin
                r13_res.pos[i] <= kind_flow
                    ? sat32(50'(signed'(r12_mid.pos[i])) + 50'(signed'(r12_mn[i])))
                    : r12_mid.pos[i];
                r13_res.dir[i] <= kind_bounce ? r12_mid.bdir[i] : r12_mid.dir[i];
            end
        end
    end

    assign o_valid = r_v13;
    assign o_res   = r13_res;

endmodule

`default_nettype wire

// ===== rtl/particle_plane_collide.sv =====
// ----------------------------------------------------------------------------
// particle_plane_collide
// Plane collider for one particle per transaction, signed Q16.16.
// ----------------------------------------------------------------------------
// The block takes one particle transaction every clock unless the output is
// stalled, and returns exactly one result per particle, in order. The 8-stage
// speed square root (four root bits per stage) that the flow response needs
// sets the pipeline depth; plane tests, step back and bounce run alongside
// it in a 5-stage front. A stall at the output freezes the whole pipeline;
// input ready follows the output register. The user must write configuration
// via the plain write port only while the block is idle; nothing enforces it.
`default_nettype none

module particle_plane_collide (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [31:0] i_cfg_data,
    ppc_in_if.sink           i_in,
    ppc_out_if.source        o_out
);
    import ppc_pkg::*;

    t_cfg        r_cfg;
    t_item       item;
    t_mid        mid;
    t_res        res;
    logic        en, mid_valid, res_valid;
    logic [63:0] sq;
    logic [31:0] len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.nx   <= '0;
            r_cfg.ny   <= '0;
            r_cfg.nz   <= '0;
            r_cfg.off  <= '0;
            r_cfg.vs   <= '0;
            r_cfg.bnc  <= BOUNCINESS_RESET;
            r_cfg.kind <= KIND_NONE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_NORMAL_X:       r_cfg.nx   <= i_cfg_data;
                REG_NORMAL_Y:       r_cfg.ny   <= i_cfg_data;
                REG_NORMAL_Z:       r_cfg.nz   <= i_cfg_data;
                REG_PLANE_OFFSET:   r_cfg.off  <= i_cfg_data;
                REG_VELOCITY_SCALE: r_cfg.vs   <= i_cfg_data;
                REG_BOUNCINESS:     r_cfg.bnc  <= i_cfg_data;
                REG_COLLISION_KIND: r_cfg.kind <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    assign en         = !res_valid || o_out.ready;
    assign i_in.ready = en;

    assign item.pos[0] = i_in.pos_x;
    assign item.pos[1] = i_in.pos_y;
    assign item.pos[2] = i_in.pos_z;
    assign item.dir[0] = i_in.dir_x;
    assign item.dir[1] = i_in.dir_y;
    assign item.dir[2] = i_in.dir_z;
    assign item.st     = i_in.step_time;

    ppc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_in.valid),
        .i_item  (item),
        .i_cfg   (r_cfg),
        .o_sq    (sq),
        .o_valid (mid_valid),
        .o_mid   (mid)
    );

    ppc_isqrt u_isqrt (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_rad  (sq),
        .o_root (len)
    );

    ppc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (mid_valid),
        .i_mid   (mid),
        .i_len   (len),
        .i_cfg   (r_cfg),
        .o_valid (res_valid),
        .o_res   (res)
    );

    assign o_out.valid     = res_valid;
    assign o_out.new_pos_x = res.pos[0];
    assign o_out.new_pos_y = res.pos[1];
    assign o_out.new_pos_z = res.pos[2];
    assign o_out.new_dir_x = res.dir[0];
    assign o_out.new_dir_y = res.dir[1];
    assign o_out.new_dir_z = res.dir[2];
    assign o_out.collided  = res.collided;

endmodule

`default_nettype wire
